### rtl/svt_pkg.sv
// svt_pkg: shared sizes, word types, register indexes and helpers for the
// summed volume table block. No dependencies.
package svt_pkg;

	// Volume limits and channel format
	localparam int MAX_WIDTH    = 256;
	localparam int MAX_HEIGHT   = 256;
	localparam int MAX_DEPTH    = 256;
	localparam int CHANNEL_BITS = 16;
	localparam int NUM_CHAN     = 4;
	localparam int SUM_BITS     = 40;

	// Coordinate widths
	localparam int X_BITS = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
	localparam int Y_BITS = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int Z_BITS = (MAX_DEPTH  > 1) ? $clog2(MAX_DEPTH)  : 1;

	// Memory geometry: row memory by x, slice memory by {y, x}
	localparam int LANE_BITS        = NUM_CHAN * SUM_BITS;
	localparam int ROW_DEPTH        = 1 << X_BITS;
	localparam int SLICE_ADDR_BITS  = X_BITS + Y_BITS;
	localparam int SLICE_DEPTH      = 1 << SLICE_ADDR_BITS;

	// Output queue
	localparam int OQ_DEPTH    = 8;
	localparam int OQ_PTR_BITS = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_BITS = $clog2(OQ_DEPTH + 1);

	// Configuration port
	localparam int CFG_BITS       = 9;
	localparam int CFG_INDEX_BITS = 2;
	localparam int RESET_SIZE     = 256;

	localparam logic [CFG_INDEX_BITS-1:0] REG_VOLUME_WIDTH  = CFG_INDEX_BITS'(0);
	localparam logic [CFG_INDEX_BITS-1:0] REG_VOLUME_HEIGHT = CFG_INDEX_BITS'(1);
	localparam logic [CFG_INDEX_BITS-1:0] REG_VOLUME_DEPTH  = CFG_INDEX_BITS'(2);

	typedef struct packed {
		logic [CHANNEL_BITS-1:0] red_in;
		logic [CHANNEL_BITS-1:0] green_in;
		logic [CHANNEL_BITS-1:0] blue_in;
		logic [CHANNEL_BITS-1:0] alpha_in;
	} in_word_t;

	typedef struct packed {
		logic [SUM_BITS-1:0] sum_red;
		logic [SUM_BITS-1:0] sum_green;
		logic [SUM_BITS-1:0] sum_blue;
		logic [SUM_BITS-1:0] sum_alpha;
		logic                last_voxel;
	} out_word_t;

	// One sum per channel: lane 0 red, 1 green, 2 blue, 3 alpha
	typedef logic [NUM_CHAN-1:0][SUM_BITS-1:0] lanes_t;

	// Size register to last coordinate: zero acts as 1, above max saturates
	function automatic logic [CFG_BITS-1:0] size_last(input logic [CFG_BITS-1:0] v,
			input int unsigned maxv);
		logic [CFG_BITS-1:0] r;
		if (v == '0) begin
			r = '0;
		end else if (32'(v) > maxv) begin
			r = CFG_BITS'(maxv - 1);
		end else begin
			r = v - 1'b1;
		end
		return r;
	endfunction

endpackage

### rtl/svt_ram.sv
// svt_ram: generic simple dual-port RAM, one write and one registered read.
// Read of the address being written returns the old contents. No dependencies.
module svt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/svt_out_queue.sv
// svt_out_queue: small FIFO of result words in front of the output channel.
// Depends on svt_pkg.
module svt_out_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  svt_pkg::out_word_t push_word,
	input  logic               pop,
	output svt_pkg::out_word_t head,
	output logic               not_empty
);

	svt_pkg::out_word_t                   mem_q [svt_pkg::OQ_DEPTH];
	logic [svt_pkg::OQ_PTR_BITS-1:0]      wr_ptr_q;
	logic [svt_pkg::OQ_PTR_BITS-1:0]      rd_ptr_q;
	logic [svt_pkg::OQ_CNT_BITS-1:0]      count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign head      = mem_q[rd_ptr_q];
	assign not_empty = (count_q != '0);

	// upstream credit scheme must keep the queue from overflowing
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != svt_pkg::OQ_CNT_BITS'(svt_pkg::OQ_DEPTH)) || pop)
		else $error("output queue overflow");

endmodule

### rtl/summed_volume_table_3d.sv
// summed_volume_table_3d: streaming 3D summed volume table, top level.
// Depends on svt_pkg, svt_ram and svt_out_queue.
//
// Voxels come in raster order (x fastest, then y, then z), one word of four
// 16-bit channels each, and every voxel gives one word of four 40-bit box
// sums from the origin to that voxel, with last_voxel set on the final voxel
// of the volume. The block takes one voxel per clock, sustained, while in_stall
// is low; an accepted word passes through stages 1 to 3 and is registered in
// the output queue before it is offered on the output.
// That rate is set by the two memories: a row memory (one entry per column,
// 160 bits) and a slice memory (one entry per x,y, 160 bits, 64K entries at
// the default sizes), each read and written once per voxel. Reads of an entry
// that the voxel just ahead is still writing are forwarded, so any volume size
// from 1x1x1 up runs at full rate. Neither memory needs clearing: an entry is
// only read after the same volume has written it. An 8-word output queue with
// credit counting keeps the pipeline moving while the output is stalled.
// Writing any size register restarts the volume at voxel (0,0,0); a size of
// zero acts as one and sizes above the maximum saturate.
module summed_volume_table_3d (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  svt_pkg::in_word_t                    in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output svt_pkg::out_word_t                   out_data,
	input  logic                                 cfg_we,
	input  logic [svt_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [svt_pkg::CFG_BITS-1:0]         cfg_data
);

	localparam int XB = svt_pkg::X_BITS;
	localparam int YB = svt_pkg::Y_BITS;
	localparam int ZB = svt_pkg::Z_BITS;
	localparam int NC = svt_pkg::NUM_CHAN;
	localparam int SB = svt_pkg::SUM_BITS;

	// ---------------- sizes and position counters ----------------
	logic [XB-1:0] width_m1_q;
	logic [YB-1:0] height_m1_q;
	logic [ZB-1:0] depth_m1_q;
	logic [XB-1:0] col_q;
	logic [YB-1:0] row_q;
	logic [ZB-1:0] slc_q;

	logic in_acc;
	logic pop;
	logic cfg_hit;
	logic last_col;
	logic last_row;
	logic last_slice;

	assign in_acc     = in_valid && !in_stall;
	assign pop        = out_valid && !out_stall;
	assign cfg_hit    = cfg_we && ((cfg_index == svt_pkg::REG_VOLUME_WIDTH) ||
		(cfg_index == svt_pkg::REG_VOLUME_HEIGHT) || (cfg_index == svt_pkg::REG_VOLUME_DEPTH));
	assign last_col   = (col_q == width_m1_q);
	assign last_row   = (row_q == height_m1_q);
	assign last_slice = (slc_q == depth_m1_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_m1_q  <= XB'(svt_pkg::size_last(svt_pkg::CFG_BITS'(svt_pkg::RESET_SIZE),
				svt_pkg::MAX_WIDTH));
			height_m1_q <= YB'(svt_pkg::size_last(svt_pkg::CFG_BITS'(svt_pkg::RESET_SIZE),
				svt_pkg::MAX_HEIGHT));
			depth_m1_q  <= ZB'(svt_pkg::size_last(svt_pkg::CFG_BITS'(svt_pkg::RESET_SIZE),
				svt_pkg::MAX_DEPTH));
		end else if (cfg_we) begin
			if (cfg_index == svt_pkg::REG_VOLUME_WIDTH) begin
				width_m1_q <= XB'(svt_pkg::size_last(cfg_data, svt_pkg::MAX_WIDTH));
			end
			if (cfg_index == svt_pkg::REG_VOLUME_HEIGHT) begin
				height_m1_q <= YB'(svt_pkg::size_last(cfg_data, svt_pkg::MAX_HEIGHT));
			end
			if (cfg_index == svt_pkg::REG_VOLUME_DEPTH) begin
				depth_m1_q <= ZB'(svt_pkg::size_last(cfg_data, svt_pkg::MAX_DEPTH));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			slc_q <= '0;
		end else if (cfg_hit) begin
			// any size write restarts the volume
			col_q <= '0;
			row_q <= '0;
			slc_q <= '0;
		end else if (in_acc) begin
			if (!last_col) begin
				col_q <= col_q + 1'b1;
			end else begin
				col_q <= '0;
				if (!last_row) begin
					row_q <= row_q + 1'b1;
				end else begin
					row_q <= '0;
					slc_q <= last_slice ? '0 : slc_q + 1'b1;
				end
			end
		end
	end

	// ---------------- stage 0: running row sum ----------------
	svt_pkg::lanes_t in_lane;
	svt_pkg::lanes_t row_sum_next;
	svt_pkg::lanes_t row_sum_q;

	always_comb begin
		in_lane[0] = SB'(in_data.red_in);
		in_lane[1] = SB'(in_data.green_in);
		in_lane[2] = SB'(in_data.blue_in);
		in_lane[3] = SB'(in_data.alpha_in);
		for (int c = 0; c < NC; c++) begin
			// first voxel of a row starts the row sum from zero
			row_sum_next[c] = ((col_q == '0) ? '0 : row_sum_q[c]) + in_lane[c];
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			row_sum_q <= row_sum_next;
		end
	end

	// ---------------- stage 1: row memory read issued ----------------
	logic            v_s1;
	svt_pkg::lanes_t rsum_s1;
	logic [XB-1:0]   x_s1;
	logic [YB-1:0]   y_s1;
	logic            up_s1;     // row above exists
	logic            back_s1;   // slice behind exists
	logic            last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		rsum_s1 <= row_sum_next;
		x_s1    <= col_q;
		y_s1    <= row_q;
		up_s1   <= (row_q != '0);
		back_s1 <= (slc_q != '0);
		last_s1 <= last_col && last_row && last_slice;
	end

	// ---------------- stage 2: slice-plane sum, row memory update ----------
	logic            v_s2;
	svt_pkg::lanes_t rsum_s2;
	logic [XB-1:0]   x_s2;
	logic [YB-1:0]   y_s2;
	logic            up_s2;
	logic            back_s2;
	logic            last_s2;

	logic [svt_pkg::LANE_BITS-1:0] row_rd;
	svt_pkg::lanes_t               up_sum;
	svt_pkg::lanes_t               plane_s2;

	// stage 3 registers declared here for forwarding
	logic            v_s3;
	svt_pkg::lanes_t plane_s3;
	logic [XB-1:0]   x_s3;
	logic [YB-1:0]   y_s3;
	logic            back_s3;
	logic            last_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		rsum_s2 <= rsum_s1;
		x_s2    <= x_s1;
		y_s2    <= y_s1;
		up_s2   <= up_s1;
		back_s2 <= back_s1;
		last_s2 <= last_s1;
	end

	svt_ram #(
		.WIDTH(svt_pkg::LANE_BITS),
		.DEPTH(svt_pkg::ROW_DEPTH)
	) u_row_ram (
		.clk   (clk),
		.we    (v_s2),
		.waddr (x_s2),
		.wdata (plane_s2),
		.raddr (x_s1),
		.rdata (row_rd)
	);

	always_comb begin
		// one-column rows: the entry was written by the voxel now in stage 3
		up_sum = (v_s3 && (x_s3 == x_s2)) ? plane_s3 : svt_pkg::lanes_t'(row_rd);
		for (int c = 0; c < NC; c++) begin
			plane_s2[c] = rsum_s2[c] + (up_s2 ? up_sum[c] : '0);
		end
	end

	// ---------------- stage 3: volume sum, slice memory update ----------
	logic [svt_pkg::SLICE_ADDR_BITS-1:0] addr_s2;
	logic [svt_pkg::SLICE_ADDR_BITS-1:0] addr_s3;
	logic [svt_pkg::LANE_BITS-1:0]       slc_rd;
	svt_pkg::lanes_t                     back_sum;
	svt_pkg::lanes_t                     total_s3;

	logic                                wb_v_q;
	logic [svt_pkg::SLICE_ADDR_BITS-1:0] wb_addr_q;
	svt_pkg::lanes_t                     wb_data_q;

	assign addr_s2 = {y_s2, x_s2};
	assign addr_s3 = {y_s3, x_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3   <= 1'b0;
			wb_v_q <= 1'b0;
		end else begin
			v_s3   <= v_s2;
			wb_v_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		plane_s3  <= plane_s2;
		x_s3      <= x_s2;
		y_s3      <= y_s2;
		back_s3   <= back_s2;
		last_s3   <= last_s2;
		wb_addr_q <= addr_s3;
		wb_data_q <= total_s3;
	end

	svt_ram #(
		.WIDTH(svt_pkg::LANE_BITS),
		.DEPTH(svt_pkg::SLICE_DEPTH)
	) u_slice_ram (
		.clk   (clk),
		.we    (v_s3),
		.waddr (addr_s3),
		.wdata (total_s3),
		.raddr (addr_s2),
		.rdata (slc_rd)
	);

	always_comb begin
		// one-voxel slices: forward the write that landed on the read edge
		back_sum = (wb_v_q && (wb_addr_q == addr_s3)) ? wb_data_q :
			svt_pkg::lanes_t'(slc_rd);
		for (int c = 0; c < NC; c++) begin
			total_s3[c] = plane_s3[c] + (back_s3 ? back_sum[c] : '0);
		end
	end

	// ---------------- output queue and credits ----------------
	svt_pkg::out_word_t              push_word;
	logic [svt_pkg::OQ_CNT_BITS-1:0] credits_q;

	always_comb begin
		push_word.sum_red    = total_s3[0];
		push_word.sum_green  = total_s3[1];
		push_word.sum_blue   = total_s3[2];
		push_word.sum_alpha  = total_s3[3];
		push_word.last_voxel = last_s3;
	end

	svt_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s3),
		.push_word (push_word),
		.pop       (pop),
		.head      (out_data),
		.not_empty (out_valid)
	);

	// credits count words accepted and not yet taken; never more than the queue holds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credits_q <= '0;
		end else begin
			unique case ({in_acc, pop})
				2'b10:   credits_q <= credits_q + 1'b1;
				2'b01:   credits_q <= credits_q - 1'b1;
				default: credits_q <= credits_q;
			endcase
		end
	end

	assign in_stall = (credits_q == svt_pkg::OQ_CNT_BITS'(svt_pkg::OQ_DEPTH));

	// ---------------- assertions ----------------
	assert property (@(posedge clk) disable iff (!arst_n)
		credits_q <= svt_pkg::OQ_CNT_BITS'(svt_pkg::OQ_DEPTH))
		else $error("credit count above queue depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (credits_q != '0))
		else $error("output word without outstanding credit");

	assert property (@(posedge clk) disable iff (!arst_n)
		(col_q <= width_m1_q) && (row_q <= height_m1_q) && (slc_q <= depth_m1_q))
		else $error("voxel position outside volume");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> ##3 v_s3)
		else $error("accepted word lost in pipeline");

endmodule

### sim/summed_volume_table_3d_tb.sv
// Self-checking testbench for summed_volume_table_3d: raster-order voxels in,
// four-channel 3D box sums out, compared word by word with an in-bench model.
// Depends on svt_pkg and the RTL of the block; nothing else.
`timescale 1ns / 1ps

module summed_volume_table_3d_tb;

	// Register index past the end of the size registers; writes there are dropped
	localparam logic [svt_pkg::CFG_INDEX_BITS-1:0] REG_SPARE =
		svt_pkg::CFG_INDEX_BITS'(3);

	localparam int RANDOM_ITEMS = 1700;
	localparam int HOLD_CYCLES  = 120;     // long output stall, fills queue and pipe
	localparam int DRAIN_CYCLES = 20;      // idle time after the last check, gives the pipeline room
	localparam int CYCLE_LIMIT  = 500000;

	typedef bit [svt_pkg::NUM_CHAN-1:0][svt_pkg::SUM_BITS-1:0] sum_lanes_t;

	// ------------------------------------------------------------------
	// Scoreboard: keeps its own copy of the sizes, voxel position, the
	// running row sums, the slice plane of the row above and the 3D box
	// sums of the previous slice. Every accepted voxel pushes one expected
	// word; every output word is checked against the oldest one.
	// ------------------------------------------------------------------
	class box_sum_scoreboard;
		int unsigned         width_cfg, height_cfg, depth_cfg;
		int unsigned         col, row, slc;
		sum_lanes_t          run_sums;
		sum_lanes_t          row_above [svt_pkg::MAX_WIDTH];
		sum_lanes_t          slice_sums [svt_pkg::MAX_WIDTH * svt_pkg::MAX_HEIGHT];
		svt_pkg::out_word_t  expected_sums [$];
		int unsigned         mismatches, checked, volumes_done;

		function new();
			width_cfg  = limit_size(svt_pkg::CFG_BITS'(svt_pkg::RESET_SIZE),
				svt_pkg::MAX_WIDTH);
			height_cfg = limit_size(svt_pkg::CFG_BITS'(svt_pkg::RESET_SIZE),
				svt_pkg::MAX_HEIGHT);
			depth_cfg  = limit_size(svt_pkg::CFG_BITS'(svt_pkg::RESET_SIZE),
				svt_pkg::MAX_DEPTH);
			mismatches = 0;
			checked = 0;
			volumes_done = 0;
			begin_volume();
		endfunction

		// zero acts as one, anything above the maximum saturates
		function int unsigned limit_size(logic [svt_pkg::CFG_BITS-1:0] v,
				int unsigned maxv);
			if (v == '0)
				return 1;
			if (32'(v) > maxv)
				return maxv;
			return 32'(v);
		endfunction

		function void begin_volume();
			col = 0;
			row = 0;
			slc = 0;
			run_sums = '0;
		endfunction

		function void set_reg(logic [svt_pkg::CFG_INDEX_BITS-1:0] idx,
				logic [svt_pkg::CFG_BITS-1:0] val);
			case (idx)
				svt_pkg::REG_VOLUME_WIDTH:  width_cfg  = limit_size(val, svt_pkg::MAX_WIDTH);
				svt_pkg::REG_VOLUME_HEIGHT: height_cfg = limit_size(val, svt_pkg::MAX_HEIGHT);
				svt_pkg::REG_VOLUME_DEPTH:  depth_cfg  = limit_size(val, svt_pkg::MAX_DEPTH);
				default:                    return;
			endcase
			begin_volume();
		endfunction

		function int unsigned pending();
			return expected_sums.size();
		endfunction

		// accepted voxel: plane sum = row sum + plane sum above,
		// box sum = plane sum + box sum one slice back
		function void note_voxel(svt_pkg::in_word_t v);
			logic [svt_pkg::CHANNEL_BITS-1:0] chan [svt_pkg::NUM_CHAN];
			sum_lanes_t plane, box;
			int unsigned slot;
			svt_pkg::out_word_t w;
			chan[0] = v.red_in;
			chan[1] = v.green_in;
			chan[2] = v.blue_in;
			chan[3] = v.alpha_in;
			slot = row * svt_pkg::MAX_WIDTH + col;
			if (col == 0)
				run_sums = '0;
			for (int c = 0; c < svt_pkg::NUM_CHAN; c++) begin
				run_sums[c] += svt_pkg::SUM_BITS'(chan[c]);
				plane[c] = run_sums[c];
				if (row > 0)
					plane[c] += row_above[col][c];
				box[c] = plane[c];
				if (slc > 0)
					box[c] += slice_sums[slot][c];
			end
			row_above[col] = plane;
			slice_sums[slot] = box;
			w.sum_red    = box[0];
			w.sum_green  = box[1];
			w.sum_blue   = box[2];
			w.sum_alpha  = box[3];
			w.last_voxel = (col + 1 >= width_cfg) && (row + 1 >= height_cfg) &&
				(slc + 1 >= depth_cfg);
			expected_sums.push_back(w);
			// raster advance, wrapping into a new volume after the last voxel
			if (col + 1 < width_cfg) begin
				col++;
			end else begin
				col = 0;
				if (row + 1 < height_cfg) begin
					row++;
				end else begin
					row = 0;
					slc = (slc + 1 < depth_cfg) ? slc + 1 : 0;
				end
			end
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		task check_sum(svt_pkg::out_word_t got);
			svt_pkg::out_word_t want;
			if (expected_sums.size() == 0) begin
				report_mismatch($sformatf("output word with nothing expected: %h", got));
				return;
			end
			want = expected_sums.pop_front();
			checked++;
			if (got.sum_red !== want.sum_red)
				report_mismatch($sformatf("word %0d sum_red %0d, want %0d",
					checked, got.sum_red, want.sum_red));
			if (got.sum_green !== want.sum_green)
				report_mismatch($sformatf("word %0d sum_green %0d, want %0d",
					checked, got.sum_green, want.sum_green));
			if (got.sum_blue !== want.sum_blue)
				report_mismatch($sformatf("word %0d sum_blue %0d, want %0d",
					checked, got.sum_blue, want.sum_blue));
			if (got.sum_alpha !== want.sum_alpha)
				report_mismatch($sformatf("word %0d sum_alpha %0d, want %0d",
					checked, got.sum_alpha, want.sum_alpha));
			if (got.last_voxel !== want.last_voxel)
				report_mismatch($sformatf("word %0d last_voxel %b, want %b",
					checked, got.last_voxel, want.last_voxel));
			if (want.last_voxel)
				volumes_done++;
		endtask
	endclass

	// ------------------------------------------------------------------
	// DUT and its drive. Everything starts at a known value at time 0.
	// ------------------------------------------------------------------
	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               in_valid = 1'b0;
	logic                               in_stall;
	svt_pkg::in_word_t                  in_data = '0;
	logic                               out_valid;
	logic                               out_stall = 1'b0;
	svt_pkg::out_word_t                 out_data;
	logic                               cfg_we = 1'b0;
	logic [svt_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [svt_pkg::CFG_BITS-1:0]       cfg_data = '0;

	box_sum_scoreboard sb = new();

	bit          calm = 1'b0;       // set for stretches with no idling at all
	int unsigned hold_reqs = 0;     // bumped by the stimulus to ask for a long stall
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;
	int unsigned items_sent = 0;
	int unsigned reg_writes = 0;
	int unsigned cycle_count = 0;

	summed_volume_table_3d dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Receiver: random stalls with a probability of about 9 in 100, none while calm, and a
	// counted hold-off whenever the stimulus asks for one. The hold runs here
	// so the sender keeps offering words while the output is blocked.
	always @(posedge clk) begin
		if (hold_reqs != hold_seen) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(99) < 9);
		end
	end

	// Output monitor: a word moves when valid is high and stall is low,
	// both as they stood just before this edge.
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0)
			sb.check_sum(out_data);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout: run stopped after %0d cycles, %0d words still expected",
				cycle_count, sb.pending());
			$display("Mismatches found");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers. Each one returns right after a rising edge, so the
	// next nonblocking drive always lands in a fresh time step.
	// ------------------------------------------------------------------
	function automatic svt_pkg::in_word_t voxel(logic [15:0] r, logic [15:0] g,
			logic [15:0] b, logic [15:0] a);
		svt_pkg::in_word_t v;
		v.red_in = r;
		v.green_in = g;
		v.blue_in = b;
		v.alpha_in = a;
		return v;
	endfunction

	// mostly uniform, with a fair share of the two extremes
	function automatic logic [svt_pkg::CHANNEL_BITS-1:0] pick_channel();
		int unsigned r;
		r = $urandom_range(9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return svt_pkg::CHANNEL_BITS'($urandom);
	endfunction

	function automatic svt_pkg::in_word_t random_voxel();
		return voxel(pick_channel(), pick_channel(), pick_channel(), pick_channel());
	endfunction

	// small sizes keep volumes short; zero exercises the acts-as-one rule
	function automatic logic [svt_pkg::CFG_BITS-1:0] pick_size();
		int unsigned r;
		r = $urandom_range(19);
		if (r == 0)
			return '0;
		if (r == 1)
			return svt_pkg::CFG_BITS'(1);
		return svt_pkg::CFG_BITS'($urandom_range(6, 2));
	endfunction

	// Offer one word, hold it steady until it is taken, then log it.
	task automatic send_voxel(input svt_pkg::in_word_t word);
		if (!calm && $urandom_range(99) < 9) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= word;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		sb.note_voxel(word);
		items_sent++;
	endtask

	// Stop offering and wait until every expected word has come back.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	task automatic write_one(input logic [svt_pkg::CFG_INDEX_BITS-1:0] idx,
			input logic [svt_pkg::CFG_BITS-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
		reg_writes++;
		cfg_we <= 1'b0;
	endtask

	// three back-to-back writes; the enable only drops after the last one
	task automatic write_sizes(input logic [svt_pkg::CFG_BITS-1:0] w,
			input logic [svt_pkg::CFG_BITS-1:0] h, input logic [svt_pkg::CFG_BITS-1:0] d);
		logic [svt_pkg::CFG_INDEX_BITS-1:0] idx [3];
		logic [svt_pkg::CFG_BITS-1:0] val [3];
		idx[0] = svt_pkg::REG_VOLUME_WIDTH;
		idx[1] = svt_pkg::REG_VOLUME_HEIGHT;
		idx[2] = svt_pkg::REG_VOLUME_DEPTH;
		val[0] = w;
		val[1] = h;
		val[2] = d;
		for (int i = 0; i < 3; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
			sb.set_reg(idx[i], val[i]);
			reg_writes++;
		end
		cfg_we <= 1'b0;
	endtask

	// One phase: program the sizes, stream count random voxels, drain.
	// spare_at > 0 pauses there until the block is empty and writes the
	// unused register index, which must not disturb the volume in progress.
	// hold asks the receiver for its long stall at the start.
	task automatic run_volume(input logic [svt_pkg::CFG_BITS-1:0] w,
			input logic [svt_pkg::CFG_BITS-1:0] h, input logic [svt_pkg::CFG_BITS-1:0] d,
			input int count, input int spare_at, input bit hold);
		write_sizes(w, h, d);
		if (hold)
			hold_reqs <= hold_reqs + 1;
		for (int i = 0; i < count; i++) begin
			if (spare_at > 0 && i == spare_at) begin
				wait_for_results();
				write_one(REG_SPARE, svt_pkg::CFG_BITS'($urandom));
			end
			send_voxel(random_voxel());
		end
		wait_for_results();
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		logic [svt_pkg::CFG_BITS-1:0] w, h, d;
		int vol, count, spare;
		int unsigned random_goal;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Straight out of reset the sizes are 256 on each axis: the first row
		// of a big volume, with the channel extremes and alternating bits.
		send_voxel(voxel(16'h0000, 16'h0000, 16'h0000, 16'h0000));
		send_voxel(voxel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_voxel(voxel(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
		send_voxel(voxel(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
		send_voxel(voxel(16'h0001, 16'h8000, 16'h7FFF, 16'hFFFE));
		send_voxel(voxel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		wait_for_results();

		// Write to the index past the register list: ignored, so the row
		// must keep running from column 6.
		write_one(REG_SPARE, 9'h1FF);
		send_voxel(voxel(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000));
		send_voxel(voxel(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF));
		wait_for_results();

		// All sizes zero act as 1x1x1: every voxel is a whole volume.
		write_sizes(9'd0, 9'd0, 9'd0);
		send_voxel(voxel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_voxel(voxel(16'h1234, 16'hFEDC, 16'h0F0F, 16'hF0F0));
		wait_for_results();

		// 2x2x2: start a volume, then restart it mid-way with a register
		// write, and run a full cube of maximum values through.
		write_sizes(9'd2, 9'd2, 9'd2);
		send_voxel(voxel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_voxel(voxel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_voxel(voxel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		wait_for_results();
		write_one(svt_pkg::REG_VOLUME_HEIGHT, 9'd2);
		for (int i = 0; i < 8; i++)
			send_voxel(voxel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		wait_for_results();

		random_goal = items_sent + RANDOM_ITEMS;

		// Width register at its all-ones value saturates to 256; two slices so
		// the slice store is used across the full row. No idling here at all.
		calm <= 1'b1;
		run_volume(9'h1FF, 9'd1, 9'd2, 2 * svt_pkg::MAX_WIDTH, 0, 1'b0);
		calm <= 1'b0;

		// Tall column (257 saturates to 256) with a pause and a dropped write
		// part way through, then a deep stack of 256 slices.
		run_volume(9'd1, 9'd257, 9'd1, svt_pkg::MAX_HEIGHT, 100, 1'b0);
		run_volume(9'd1, 9'd1, 9'd256, svt_pkg::MAX_DEPTH, 0, 1'b0);

		// Back-pressure: the output stalls for a long stretch while voxels keep
		// coming, so the output queue fills and the input stall has to rise.
		run_volume(9'd4, 9'd4, 9'd4, 128, 0, 1'b1);

		// Random small volumes: mostly whole volumes, one or more back to back,
		// with some cut short (next size write restarts them) or running past
		// the end into a partial next volume.
		while (items_sent < random_goal) begin
			w = pick_size();
			h = pick_size();
			d = pick_size();
			vol = (w == 0 ? 1 : int'(w)) * (h == 0 ? 1 : int'(h)) * (d == 0 ? 1 : int'(d));
			if ($urandom_range(4) == 0)
				count = $urandom_range(2 * vol, 1);
			else
				count = vol * $urandom_range(3, 1);
			spare = ($urandom_range(5) == 0) ? $urandom_range(count, 1) : 0;
			run_volume(w, h, d, count, spare, 1'b0);
		end

		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d voxel sums, %0d complete volumes, %0d register writes.",
			sb.checked, sb.volumes_done, reg_writes);
		$display("Sizes from 1x1x1 to 256 per axis, saturation, restarts and a full-queue stall.");
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
